/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/fbb_pkg.sv */
// Shared types and constants for the framebuffer blitter.
// No dependencies; used by the copy sequencer, the top level and the checker.
package fbb_pkg;

  localparam int SRC_ADDR_BITS = 16;
  localparam int FB_SIDE       = 32;
  localparam int FB_ADDR_BITS  = 10;
  localparam int PIX_BITS      = 8;

  localparam logic [15:0] SRC_RESET = 16'hCC00;

  localparam logic [1:0] FUNC_REG = 2'd0;
  localparam logic [1:0] FUNC_MEM = 2'd1;
  localparam logic [1:0] FUNC_PIX = 2'd2;

  localparam logic [4:0] REG_COPY_FLUSH = 5'd0;
  localparam logic [4:0] REG_COPY       = 5'd1;
  localparam logic [4:0] REG_SRC_LO     = 5'd2;
  localparam logic [4:0] REG_SRC_HI     = 5'd3;
  localparam logic [4:0] REG_DST_LO     = 5'd4;
  localparam logic [4:0] REG_DST_HI     = 5'd5;
  localparam logic [4:0] REG_DST_X      = 5'd6;
  localparam logic [4:0] REG_DST_Y      = 5'd7;
  localparam logic [4:0] REG_WIDTH      = 5'd8;
  localparam logic [4:0] REG_HEIGHT     = 5'd9;
  localparam logic [4:0] REG_STRIDE     = 5'd10;
  localparam logic [4:0] REG_KEY        = 5'd11;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [1:0] SEL_SKIP_KEY = 2'd1;
  localparam logic [1:0] SEL_ONLY_KEY = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  reg_addr;
    logic [15:0] mem_addr;
    logic [9:0]  pixel_index;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
  } out_item_t;

  typedef struct packed {
    logic [15:0] src_address;
    logic [9:0]  dest_address;
    logic [4:0]  width_minus_one;
    logic [4:0]  height_minus_one;
    logic [7:0]  stride_minus_one;
    logic [7:0]  key_color;
  } copy_cfg_t;

  typedef struct packed {
    logic       start;
    logic [2:0] mode;
  } copy_cmd_t;

endpackage

/* hdl/fbb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbb_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fbb_copy_seq.sv */
// Rectangle copy sequencer: walks the rectangle, one read then, unless skipped, one write per pixel.
// Depends on fbb_pkg; drives the source and frame RAM ports.
module fbb_copy_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  fbb_pkg::copy_cmd_t                cmd,
  input  fbb_pkg::copy_cfg_t                cfg,
  output logic [fbb_pkg::SRC_ADDR_BITS-1:0] src_raddr,
  input  logic [fbb_pkg::PIX_BITS-1:0]      src_rdata,
  output logic [fbb_pkg::FB_ADDR_BITS-1:0]  fb_raddr,
  input  logic [fbb_pkg::PIX_BITS-1:0]      fb_rdata,
  output logic                              fb_we,
  output logic [fbb_pkg::FB_ADDR_BITS-1:0]  fb_waddr,
  output logic [fbb_pkg::PIX_BITS-1:0]      fb_wdata,
  output logic                              done
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

  state_t      state;
  logic [4:0]  x;
  logic [4:0]  y;
  logic [15:0] row_src;
  logic [10:0] row_dst;
  logic [10:0] da;
  logic [10:0] da_q;
  logic [15:0] sa;
  logic [2:0]  mode;
  logic        skip;
  logic        last_col;
  logic        last_row;
  logic [8:0]  stride;

  // address adders: row base plus column, for source and frame store
  assign sa       = row_src + {11'd0, x};
  assign da       = row_dst + {6'd0, x};
  assign stride   = {1'b0, cfg.stride_minus_one} + 9'd1;
  assign last_col = (x == cfg.width_minus_one);
  assign last_row = (y == cfg.height_minus_one);

  assign src_raddr = sa[fbb_pkg::SRC_ADDR_BITS-1:0];
  assign fb_raddr  = da[fbb_pkg::FB_ADDR_BITS-1:0];

  always_comb begin
    skip = da_q[10];
    if (mode[0] && src_rdata == cfg.key_color) begin
      skip = 1'b1;
    end
    if (mode[2:1] == fbb_pkg::SEL_SKIP_KEY && fb_rdata == cfg.key_color) begin
      skip = 1'b1;
    end
    if (mode[2:1] == fbb_pkg::SEL_ONLY_KEY && fb_rdata != cfg.key_color) begin
      skip = 1'b1;
    end
  end

  assign fb_we    = (state == S_WRITE) && !skip;
  assign fb_waddr = da_q[fbb_pkg::FB_ADDR_BITS-1:0];
  assign fb_wdata = src_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            mode    <= cmd.mode;
            x       <= 5'd0;
            y       <= 5'd0;
            row_src <= cfg.src_address;
            row_dst <= {1'b0, cfg.dest_address};
            state   <= S_READ;
          end
        end
        S_READ: begin
          da_q  <= da;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (last_col) begin
            x <= 5'd0;
            if (last_row) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              y       <= y + 5'd1;
              row_src <= row_src + {7'd0, stride};
              row_dst <= row_dst + 11'(fbb_pkg::FB_SIDE);
              state   <= S_READ;
            end
          end else begin
            x     <= x + 5'd1;
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/framebuffer_blitter_regs.sv */
// Top level of the framebuffer blitter: bus decode, registers, memories, result register.
// Depends on fbb_pkg, fbb_ram and fbb_copy_seq.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | fbb_pkg::in_item_t
//   out     | output    | out_valid / out_ready| fbb_pkg::out_item_t
//
// Register and memory write items complete on acceptance; a pixel read passes through
// the frame store's registered read port and the ST_PREAD state into the result register.
// A copy reads source and frame store, then writes unless skipped, for each pixel in turn.
// After reset the frame store is zeroed, all 1024 entries, with in_ready low throughout.
// An item that gives a result waits at the input while an earlier result is untaken.
module framebuffer_blitter_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fbb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fbb_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PREAD, ST_COPY} state_t;

  state_t              state;
  logic [9:0]          clr_cnt;
  fbb_pkg::copy_cfg_t  cfg;
  fbb_pkg::copy_cmd_t  cmd;
  logic                flush;
  logic                accept;
  logic                makes_result;
  logic                is_reg;
  logic                is_copy;

  logic [fbb_pkg::SRC_ADDR_BITS-1:0] seq_src_raddr;
  logic [fbb_pkg::PIX_BITS-1:0]      src_rdata;
  logic [fbb_pkg::FB_ADDR_BITS-1:0]  seq_fb_raddr;
  logic [fbb_pkg::FB_ADDR_BITS-1:0]  fb_raddr;
  logic [fbb_pkg::PIX_BITS-1:0]      fb_rdata;
  logic                              seq_fb_we;
  logic [fbb_pkg::FB_ADDR_BITS-1:0]  seq_fb_waddr;
  logic [fbb_pkg::PIX_BITS-1:0]      seq_fb_wdata;
  logic                              fb_we;
  logic [fbb_pkg::FB_ADDR_BITS-1:0]  fb_waddr;
  logic [fbb_pkg::PIX_BITS-1:0]      fb_wdata;
  logic                              src_we;
  logic                              copy_done;

  assign is_reg  = (in_item.func == fbb_pkg::FUNC_REG);
  assign is_copy = is_reg && (in_item.reg_addr == fbb_pkg::REG_COPY_FLUSH
                              || in_item.reg_addr == fbb_pkg::REG_COPY);
  assign makes_result = (in_item.func == fbb_pkg::FUNC_PIX)
                        || (is_reg && in_item.reg_addr == fbb_pkg::REG_COPY_FLUSH);

  assign in_ready = (state == ST_IDLE) && !(out_valid && makes_result);
  assign accept   = in_valid && in_ready;

  assign cmd.start = accept && is_copy;
  assign cmd.mode  = in_item.data[2:0];

  assign src_we = accept && (in_item.func == fbb_pkg::FUNC_MEM);

  // frame store ports: clearing pass, then copy engine or pixel read
  always_comb begin
    if (state == ST_CLEAR) begin
      fb_we    = 1'b1;
      fb_waddr = clr_cnt;
      fb_wdata = '0;
    end else begin
      fb_we    = seq_fb_we;
      fb_waddr = seq_fb_waddr;
      fb_wdata = seq_fb_wdata;
    end
    fb_raddr = (state == ST_COPY) ? seq_fb_raddr : in_item.pixel_index;
  end

  fbb_ram #(
    .ADDR_BITS(fbb_pkg::SRC_ADDR_BITS),
    .DATA_BITS(fbb_pkg::PIX_BITS)
  ) u_src_ram (
    .clk  (clk),
    .we   (src_we),
    .waddr(in_item.mem_addr[fbb_pkg::SRC_ADDR_BITS-1:0]),
    .wdata(in_item.data),
    .raddr(seq_src_raddr),
    .rdata(src_rdata)
  );

  fbb_ram #(
    .ADDR_BITS(fbb_pkg::FB_ADDR_BITS),
    .DATA_BITS(fbb_pkg::PIX_BITS)
  ) u_fb_ram (
    .clk  (clk),
    .we   (fb_we),
    .waddr(fb_waddr),
    .wdata(fb_wdata),
    .raddr(fb_raddr),
    .rdata(fb_rdata)
  );

  fbb_copy_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .src_raddr(seq_src_raddr),
    .src_rdata(src_rdata),
    .fb_raddr (seq_fb_raddr),
    .fb_rdata (fb_rdata),
    .fb_we    (seq_fb_we),
    .fb_waddr (seq_fb_waddr),
    .fb_wdata (seq_fb_wdata),
    .done     (copy_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_CLEAR;
      clr_cnt              <= '0;
      out_valid            <= 1'b0;
      flush                <= 1'b0;
      cfg.src_address      <= fbb_pkg::SRC_RESET;
      cfg.dest_address     <= '0;
      cfg.width_minus_one  <= 5'd31;
      cfg.height_minus_one <= 5'd31;
      cfg.stride_minus_one <= 8'd31;
      cfg.key_color        <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 10'd1;
          if (clr_cnt == 10'd1023) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_item.func == fbb_pkg::FUNC_PIX) begin
              state <= ST_PREAD;
            end else if (is_copy) begin
              flush <= (in_item.reg_addr == fbb_pkg::REG_COPY_FLUSH);
              state <= ST_COPY;
            end else if (is_reg) begin
              unique case (in_item.reg_addr)
                fbb_pkg::REG_SRC_LO: cfg.src_address[7:0]  <= in_item.data;
                fbb_pkg::REG_SRC_HI: cfg.src_address[15:8] <= in_item.data;
                fbb_pkg::REG_DST_LO: cfg.dest_address[7:0] <= in_item.data;
                fbb_pkg::REG_DST_HI: cfg.dest_address[9:8] <= in_item.data[1:0];
                fbb_pkg::REG_DST_X:  cfg.dest_address[4:0] <= in_item.data[4:0];
                fbb_pkg::REG_DST_Y:  cfg.dest_address[9:5] <= in_item.data[4:0];
                fbb_pkg::REG_WIDTH:  cfg.width_minus_one   <= in_item.data[4:0];
                fbb_pkg::REG_HEIGHT: cfg.height_minus_one  <= in_item.data[4:0];
                fbb_pkg::REG_STRIDE: cfg.stride_minus_one  <= in_item.data;
                fbb_pkg::REG_KEY:    cfg.key_color         <= in_item.data;
                default: ;
              endcase
            end
          end
        end
        ST_PREAD: begin
          out_valid      <= 1'b1;
          out_item.kind  <= fbb_pkg::KIND_PIXEL;
          out_item.pixel <= fb_rdata;
          state          <= ST_IDLE;
        end
        ST_COPY: begin
          if (copy_done) begin
            if (flush) begin
              out_valid      <= 1'b1;
              out_item.kind  <= fbb_pkg::KIND_FLUSH;
              out_item.pixel <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/fbb_checker.sv */
// Port-level checker for the framebuffer blitter, bound to the top level.
// Depends on fbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input fbb_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input fbb_pkg::out_item_t out_item
);

  logic pix_acc;
  logic flush_out;
  logic pix_out;

  assign pix_acc   = in_valid && in_ready && (in_item.func == fbb_pkg::FUNC_PIX);
  assign flush_out = out_valid && (out_item.kind == fbb_pkg::KIND_FLUSH);
  assign pix_out   = out_valid && (out_item.kind == fbb_pkg::KIND_PIXEL);

  // result holds until taken
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
  // flush items carry no pixel
  `ASSERT_IMPL(a_flush_zero, clk, rst, flush_out, out_item.pixel == 8'd0)
  // frame store clearing keeps the input closed straight after reset
  `ASSERT_NEXT_ALWAYS(a_clear_closed, clk, rst, !in_ready)
  // a pixel read is only taken with the result register free, and is then answered with a pixel item
  `ASSERT_IMPL(a_pix_free, clk, rst, pix_acc, !out_valid)
  `ASSERT_IMPL(a_pix_answer, clk, rst, pix_acc, ##2 pix_out)

endmodule

bind framebuffer_blitter_regs fbb_checker u_fbb_checker (.*);
